### rtl/gcd_pkg.sv
// ============================================================================
// gcd_pkg
// Shared constants, widths and CORDIC tables for the great-circle distance
// pipeline.
// ============================================================================
package gcd_pkg;

  // Width of the CORDIC x/y datapath and of the angle accumulator (Q24).
  localparam int XW = 28;
  localparam int ZW = 28;

  // Width of the arc-cosine result angle, 0..pi in Q24.
  localparam int ANG_W = 26;

  localparam logic signed [XW-1:0] GAIN_Q24    = XW'(10188014);
  localparam logic signed [ZW-1:0] PI_Q24      = ZW'(52707179);
  localparam logic signed [XW-1:0] ONE_Q24     = XW'(1 << 24);
  localparam logic [26:0]          DEG2RAD_Q32 = 27'd74961321;
  localparam logic [12:0]          EARTH_KM    = 13'd6371;

  // Arctangent table, round(atan(2^-k) * 2^24).
  function automatic logic signed [ZW-1:0] atan_q24(input int k);
    logic signed [ZW-1:0] v;
    unique case (k)
      0:  v = ZW'(13176795);
      1:  v = ZW'(7778716);
      2:  v = ZW'(4110060);
      3:  v = ZW'(2086331);
      4:  v = ZW'(1047214);
      5:  v = ZW'(524117);
      6:  v = ZW'(262123);
      7:  v = ZW'(131069);
      8:  v = ZW'(65536);
      9:  v = ZW'(32768);
      10: v = ZW'(16384);
      11: v = ZW'(8192);
      12: v = ZW'(4096);
      13: v = ZW'(2048);
      14: v = ZW'(1024);
      15: v = ZW'(512);
      16: v = ZW'(256);
      17: v = ZW'(128);
      18: v = ZW'(64);
      19: v = ZW'(32);
      20: v = ZW'(16);
      21: v = ZW'(8);
      22: v = ZW'(4);
      23: v = ZW'(2);
      24: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // Smallest shift s such that (turn << s) reaches 2^(aw-1).
  function automatic int turn_shift(input longint turn, input int aw);
    int s;
    s = 0;
    while ((turn << s) < (longint'(1) << (aw - 1))) begin
      s++;
    end
    return s;
  endfunction

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### rtl/gcd_sincos.sv
// ============================================================================
// gcd_sincos
// Pipelined sine/cosine of a fixed-point angle in degrees: modulo-360
// reduction one quotient bit per stage, quadrant fold, conversion to
// radians, then one rotation-mode CORDIC step per stage.
// ============================================================================
module gcd_sincos
  import gcd_pkg::*;
#(
  parameter int F     = 16,
  parameter int STEPS = 24,
  parameter int AW    = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [AW-1:0] angle,
  output logic                 out_vld,
  output logic signed [XW-1:0] sin_o,
  output logic signed [XW-1:0] cos_o
);

  localparam longint TURN = longint'(360) << F;
  localparam int     SH   = turn_shift(TURN, AW);
  localparam int     NR   = SH + 2;
  localparam int     RW   = AW + 1;
  localparam int     MW   = F + 7;
  localparam int     PW   = MW + 27;

  localparam logic [RW-1:0]        OFFSET = RW'(TURN << SH);
  localparam logic signed [RW:0]   FULL_S = (RW+1)'(TURN);
  localparam logic signed [RW:0]   HALF_S = (RW+1)'(TURN / 2);
  localparam logic signed [RW:0]   QUAR_S = (RW+1)'(TURN / 4);

  // Reduction stages.
  logic [RW-1:0] red_r [0:NR];
  logic [NR:0]   rvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rvld_r[0] <= 1'b0;
    end else if (en) begin
      rvld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r[0] <= RW'(angle) + OFFSET;
    end
  end

  for (genvar j = 1; j <= NR; j++) begin : g_red
    localparam logic [RW-1:0] DIV = RW'(TURN << (NR - j));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        rvld_r[j] <= 1'b0;
      end else if (en) begin
        rvld_r[j] <= rvld_r[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        red_r[j] <= (red_r[j-1] >= DIV) ? red_r[j-1] - DIV : red_r[j-1];
      end
    end
  end

  // Fold into [-90, 90] degrees.
  logic signed [RW:0] rs, fd;
  logic               fold;
  logic [MW-1:0]      mag_nxt;

  always_comb begin
    rs = signed'({1'b0, red_r[NR]});
    if (rs >= HALF_S) begin
      rs = rs - FULL_S;
    end
    fd   = rs;
    fold = 1'b0;
    if (rs > QUAR_S) begin
      fd   = HALF_S - rs;
      fold = 1'b1;
    end else if (rs < -QUAR_S) begin
      fd   = -HALF_S - rs;
      fold = 1'b1;
    end
    mag_nxt = (fd < 0) ? MW'(-fd) : MW'(fd);
  end

  logic [MW-1:0] mag_r;
  logic [PW-1:0] prod_r;
  logic          neg_r, neg2_r, flip_r, flip2_r, fvld_r, pvld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r <= 1'b0;
      pvld_r <= 1'b0;
    end else if (en) begin
      fvld_r <= rvld_r[NR];
      pvld_r <= fvld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= mag_nxt;
      neg_r   <= fd < 0;
      flip_r  <= fold;
      prod_r  <= PW'(mag_r) * PW'(DEG2RAD_Q32);
      neg2_r  <= neg_r;
      flip2_r <= flip_r;
    end
  end

  // Round half away from zero to Q24 radians.
  logic [PW-1:0]        rnd;
  logic signed [ZW-1:0] z0;

  always_comb begin
    rnd = (prod_r + (PW'(1) << (F + 7))) >> (F + 8);
    z0  = neg2_r ? -ZW'(rnd) : ZW'(rnd);
  end

  logic signed [ZW-1:0] z0_r;
  logic                 f0_r, v0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= pvld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z0_r <= z0;
      f0_r <= flip2_r;
    end
  end

  // CORDIC rotation, one step per stage.
  logic signed [XW-1:0] x_r [0:STEPS-1];
  logic signed [XW-1:0] y_r [0:STEPS-1];
  logic signed [ZW-1:0] z_r [0:STEPS-1];
  logic                 cf_r [0:STEPS-1];
  logic [STEPS-1:0]     cv_r;

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [XW-1:0] xp, yp;
    logic signed [ZW-1:0] zp;
    logic                 fp, vp;
    if (i == 0) begin : g_first
      assign xp = GAIN_Q24;
      assign yp = '0;
      assign zp = z0_r;
      assign fp = f0_r;
      assign vp = v0_r;
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
      assign fp = cf_r[i-1];
      assign vp = cv_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i] <= 1'b0;
      end else if (en) begin
        cv_r[i] <= vp;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cf_r[i] <= fp;
        if (zp >= 0) begin
          x_r[i] <= xp - (yp >>> i);
          y_r[i] <= yp + (xp >>> i);
          z_r[i] <= zp - atan_q24(i);
        end else begin
          x_r[i] <= xp + (yp >>> i);
          y_r[i] <= yp - (xp >>> i);
          z_r[i] <= zp + atan_q24(i);
        end
      end
    end
  end

  assign out_vld = cv_r[STEPS-1];
  assign sin_o   = y_r[STEPS-1];
  assign cos_o   = cf_r[STEPS-1] ? -x_r[STEPS-1] : x_r[STEPS-1];

endmodule

### rtl/gcd_combine.sv
// ============================================================================
// gcd_combine
// Forms the law-of-cosines term, clamps it to [-1, 1] and prepares the
// radicand 1 - c^2 for the square root.
// ============================================================================
module gcd_combine
  import gcd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic signed [XW-1:0] sin_a,
  input  logic signed [XW-1:0] cos_a,
  input  logic signed [XW-1:0] sin_b,
  input  logic signed [XW-1:0] cos_b,
  input  logic signed [XW-1:0] cos_d,
  output logic                 out_vld,
  output logic [48:0]          rad_o,
  output logic [24:0]          abs_o,
  output logic                 neg_o
);

  logic signed [2*XW-1:0] pss, pcc, ptc;
  logic signed [XW-1:0]   t_r, cc_r, cd_r;
  logic signed [XW:0]     c_r, cl;
  logic [24:0]            ax_r;
  logic                   ng_r;
  logic [2:0]             vld_r;

  assign pss = sin_a * sin_b;
  assign pcc = cos_a * cos_b;
  assign ptc = t_r * cd_r;

  always_comb begin
    cl = c_r;
    if (c_r > (XW+1)'(ONE_Q24)) begin
      cl = (XW+1)'(ONE_Q24);
    end else if (c_r < -(XW+1)'(ONE_Q24)) begin
      cl = -(XW+1)'(ONE_Q24);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vld_r   <= {vld_r[1:0], in_vld};
      out_vld <= vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r   <= XW'(pss >>> 24);
      cc_r  <= XW'(pcc >>> 24);
      cd_r  <= cos_d;
      c_r   <= (XW+1)'(ptc >>> 24) + (XW+1)'(cc_r);
      ax_r  <= (cl < 0) ? 25'(-cl) : 25'(cl);
      ng_r  <= cl < 0;
      rad_o <= (49'(1) << 48) - 49'(50'(ax_r) * 50'(ax_r));
      abs_o <= ax_r;
      neg_o <= ng_r;
    end
  end

endmodule

### rtl/gcd_acos.sv
// ============================================================================
// gcd_acos
// Arc cosine: a pipelined integer square root gives sin from 1 - c^2, then
// a vectoring CORDIC finds the angle, mirrored about pi/2 for negative c.
// ============================================================================
module gcd_acos
  import gcd_pkg::*;
#(
  parameter int STEPS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [48:0]      rad_i,
  input  logic [24:0]      abs_i,
  input  logic             neg_i,
  output logic             out_vld,
  output logic [ANG_W-1:0] ang_o
);

  localparam int NS = 25;

  // Square root, one result bit per stage.
  logic [49:0] sv_r [0:NS];
  logic [49:0] sr_r [0:NS];
  logic [24:0] sa_r [0:NS];
  logic        sn_r [0:NS];
  logic [NS:0] svld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      svld_r[0] <= 1'b0;
    end else if (en) begin
      svld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sv_r[0] <= 50'(rad_i);
      sr_r[0] <= '0;
      sa_r[0] <= abs_i;
      sn_r[0] <= neg_i;
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_sqrt
    localparam logic [49:0] BIT = 50'(1) << (50 - 2 * j);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        svld_r[j] <= 1'b0;
      end else if (en) begin
        svld_r[j] <= svld_r[j-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sa_r[j] <= sa_r[j-1];
        sn_r[j] <= sn_r[j-1];
        if (sv_r[j-1] >= sr_r[j-1] + BIT) begin
          sv_r[j] <= sv_r[j-1] - (sr_r[j-1] + BIT);
          sr_r[j] <= (sr_r[j-1] >> 1) + BIT;
        end else begin
          sv_r[j] <= sv_r[j-1];
          sr_r[j] <= sr_r[j-1] >> 1;
        end
      end
    end
  end

  // Vectoring CORDIC on (|c|, sqrt(1 - c^2)).
  logic signed [XW-1:0] x_r [0:STEPS-1];
  logic signed [XW-1:0] y_r [0:STEPS-1];
  logic signed [ZW-1:0] z_r [0:STEPS-1];
  logic                 n_r [0:STEPS-1];
  logic [STEPS-1:0]     v_r;

  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    logic signed [XW-1:0] xp, yp;
    logic signed [ZW-1:0] zp;
    logic                 np, vp;
    if (i == 0) begin : g_first
      assign xp = XW'(sa_r[NS]);
      assign yp = XW'(sr_r[NS]);
      assign zp = '0;
      assign np = sn_r[NS];
      assign vp = svld_r[NS];
    end else begin : g_next
      assign xp = x_r[i-1];
      assign yp = y_r[i-1];
      assign zp = z_r[i-1];
      assign np = n_r[i-1];
      assign vp = v_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= vp;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i] <= np;
        if (yp > 0) begin
          x_r[i] <= xp + (yp >>> i);
          y_r[i] <= yp - (xp >>> i);
          z_r[i] <= zp + atan_q24(i);
        end else begin
          x_r[i] <= xp - (yp >>> i);
          y_r[i] <= yp + (xp >>> i);
          z_r[i] <= zp - atan_q24(i);
        end
      end
    end
  end

  logic signed [ZW-1:0] zf;

  always_comb begin
    zf = n_r[STEPS-1] ? PI_Q24 - z_r[STEPS-1] : z_r[STEPS-1];
    if (zf < 0) begin
      zf = '0;
    end else if (zf > PI_Q24) begin
      zf = PI_Q24;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ang_o <= ANG_W'(zf);
    end
  end

endmodule

### rtl/great_circle_distance.sv
// ============================================================================
// great_circle_distance
// Spherical law-of-cosines distance between two points, in whole km.
// ============================================================================
// Usage: each input transaction carries two points as latitude/longitude in
// signed degrees with ANGLE_FRAC_BITS fraction bits; each output transaction
// carries the distance on a 6371 km sphere, truncated toward zero.
// Both channels use valid/ready. One transaction is accepted per cycle while in_ready is high, and
// every input transaction yields exactly one output transaction, in order.
// Inputs pass through the three sine/cosine units (the modulo-360 reduction
// runs SH+2 compare-and-subtract stages, and SH is 1 at the default
// settings), then the combine stage, the arc cosine and the registered
// output multiply.
// Throughput is one transaction per clock while the output is not stalled; the
// whole pipeline advances on a single enable, so the rate is set by the output register alone.
// When the receiver stalls, the result holds on the ports and every stage
// holds in place; in_ready drops for those cycles and nothing is lost.
// A synchronous active-low reset clears all valid bits; data registers are
// not reset. Nothing is kept from one transaction to the next.
// ============================================================================
module great_circle_distance
  import gcd_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STEPS    = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] in_lat_a,
  input  logic signed [24:0] in_lon_a,
  input  logic signed [23:0] in_lat_b,
  input  logic signed [24:0] in_lon_b,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [14:0]        out_distance_km
);

  // Angle width: holds 90 degrees minus any latitude, and any longitude
  // difference, with sign.
  localparam int AW = imax(ANGLE_FRAC_BITS + 9, 26);

  localparam logic signed [AW-1:0] RIGHT = AW'(longint'(90) << ANGLE_FRAC_BITS);

  // The pipeline moves whenever the output register is free or being read.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic signed [AW-1:0] colat_a, colat_b, dlon;
  assign colat_a = RIGHT - AW'(in_lat_a);
  assign colat_b = RIGHT - AW'(in_lat_b);
  assign dlon    = AW'(in_lon_a) - AW'(in_lon_b);

  logic                 in_take;
  assign in_take = in_valid && in_ready;

  logic                 va, vb, vd;
  logic signed [XW-1:0] sa, ca, sb, cb, sd, cd;

  gcd_sincos #(.F(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS), .AW(AW)) u_sc_a (
    .clk, .rst_n, .en, .in_vld(in_take), .angle(colat_a),
    .out_vld(va), .sin_o(sa), .cos_o(ca)
  );

  gcd_sincos #(.F(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS), .AW(AW)) u_sc_b (
    .clk, .rst_n, .en, .in_vld(in_take), .angle(colat_b),
    .out_vld(vb), .sin_o(sb), .cos_o(cb)
  );

  gcd_sincos #(.F(ANGLE_FRAC_BITS), .STEPS(CORDIC_STEPS), .AW(AW)) u_sc_d (
    .clk, .rst_n, .en, .in_vld(in_take), .angle(dlon),
    .out_vld(vd), .sin_o(sd), .cos_o(cd)
  );

  // Only the cosine of the longitude difference enters the formula.
  logic                 sc_vld;
  logic signed [XW-1:0] sd_unused;
  assign sd_unused = sd;
  assign sc_vld    = va && vb && vd && (sd_unused == sd);

  logic        cm_vld, cm_neg;
  logic [48:0] cm_rad;
  logic [24:0] cm_abs;

  gcd_combine u_comb (
    .clk, .rst_n, .en, .in_vld(sc_vld),
    .sin_a(sa), .cos_a(ca), .sin_b(sb), .cos_b(cb), .cos_d(cd),
    .out_vld(cm_vld), .rad_o(cm_rad), .abs_o(cm_abs), .neg_o(cm_neg)
  );

  logic             ac_vld;
  logic [ANG_W-1:0] ang;

  gcd_acos #(.STEPS(CORDIC_STEPS)) u_acos (
    .clk, .rst_n, .en, .in_vld(cm_vld),
    .rad_i(cm_rad), .abs_i(cm_abs), .neg_i(cm_neg),
    .out_vld(ac_vld), .ang_o(ang)
  );

  // Scale the angle by the sphere radius and drop the Q24 fraction.
  logic [ANG_W+12:0] km_full;
  assign km_full = (ANG_W+13)'(ang) * (ANG_W+13)'(EARTH_KM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ac_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_distance_km <= km_full[38:24];
    end
  end

  a_dist_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_distance_km <= 15'd20015)
    else $error("distance beyond half the circumference");

  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_rise_on_advance : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_ready))
    else $error("result appeared while the pipeline was stalled");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Great-circle distance testbench
// Sends point pairs through the valid/ready input channel, predicts each
// distance with a bit-exact fixed-point model of the pipeline, and compares
// every output transaction in order. A directed table comes first, then
// random pairs under three idle patterns on both channels.
// ============================================================================
module tb;

  localparam int FRAC       = 16;
  localparam int STEPS      = 24;
  localparam int N_RANDOM   = 1330;
  localparam int LAT_MAX    = 5898240;
  localparam int LON_MAX    = 11796480;
  localparam longint CYCLE_LIMIT = 2000000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [23:0] in_lat_a;
  logic signed [24:0] in_lon_a;
  logic signed [23:0] in_lat_b;
  logic signed [24:0] in_lon_b;
  logic               out_valid;
  logic               out_ready;
  logic [14:0]        out_distance_km;

  great_circle_distance #(.ANGLE_FRAC_BITS(FRAC), .CORDIC_STEPS(STEPS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_lat_a(in_lat_a), .in_lon_a(in_lon_a),
    .in_lat_b(in_lat_b), .in_lon_b(in_lon_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_distance_km(out_distance_km)
  );

  // One point pair and, where it is obvious, the distance it must give.
  // A known value of -1 means the row is checked against the predictor only.
  typedef struct {
    logic signed [23:0] lat_a;
    logic signed [24:0] lon_a;
    logic signed [23:0] lat_b;
    logic signed [24:0] lon_b;
    int                 known_km;
  } pair_row_t;

  logic [14:0] pending_km[$];
  int          errors;
  int          results_seen;
  int          send_idle_pct;
  int          recv_idle_pct;
  longint      cycle_count;

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // The atan table of the CORDIC stages, round(atan(2^-k) * 2^24).
  function automatic longint atan_step(input int k);
    longint tbl[25] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
                        262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048,
                        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    if (k > 24) return 0;
    return tbl[k];
  endfunction

  // Degrees in the input scale to Q24 radians, rounding half away from zero.
  function automatic longint degrees_to_q24(input longint d);
    longint mag;
    mag = (d < 0) ? -d : d;
    mag = (mag * 64'd74961321 + (64'd1 << (FRAC + 7))) >>> (FRAC + 8);
    return (d < 0) ? -mag : mag;
  endfunction

  // Rotation CORDIC after folding the angle into [-90, 90] degrees.
  function automatic void sine_cosine(input longint a, output longint s,
                                      output longint c);
    longint full, half, quarter, r, x, y, z, nx, ny;
    bit flip;
    full = 360 <<< FRAC;
    half = full / 2;
    quarter = full / 4;
    r = a % full;
    flip = 1'b0;
    if (r < 0) r += full;
    if (r >= half) r -= full;
    if (r > quarter) begin
      r = half - r;
      flip = 1'b1;
    end else if (r < -quarter) begin
      r = -half - r;
      flip = 1'b1;
    end
    z = degrees_to_q24(r);
    x = 10188014;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step(i);
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step(i);
      end
      x = nx;
      y = ny;
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic longint floor_sqrt48(input longint v);
    longint res, b;
    res = 0;
    b = longint'(1) << 48;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // Vectoring CORDIC on (|c|, sqrt(1-c^2)), mirrored for a negative cosine.
  function automatic longint arc_cosine(input longint c);
    longint x, y, z, nx, ny;
    x = (c < 0) ? -c : c;
    y = floor_sqrt48((longint'(1) << 48) - c * c);
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step(i);
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step(i);
      end
      x = nx;
      y = ny;
    end
    if (c < 0) z = 52707179 - z;
    if (z < 0) z = 0;
    if (z > 52707179) z = 52707179;
    return z;
  endfunction

  function automatic logic [14:0] distance_km(input pair_row_t p);
    longint sa, ca, sb, cb, sd, cd, t, c, ang, right;
    right = 90 <<< FRAC;
    sine_cosine(right - longint'(p.lat_a), sa, ca);
    sine_cosine(right - longint'(p.lat_b), sb, cb);
    sine_cosine(longint'(p.lon_a) - longint'(p.lon_b), sd, cd);
    t = (sa * sb) >>> 24;
    c = ((t * cd) >>> 24) + ((ca * cb) >>> 24);
    if (c > (longint'(1) << 24)) c = longint'(1) << 24;
    if (c < -(longint'(1) << 24)) c = -(longint'(1) << 24);
    ang = arc_cosine(c);
    return 15'((ang * 6371) >>> 24);
  endfunction

  function automatic bit idle_roll(input int pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  // Hand one transaction to the block and queue its expected distance.
  // Valid drops only while the sender idles, so back-to-back transactions
  // keep it high across the accepting edge.
  task automatic send_pair(input pair_row_t p);
    logic [14:0] want;
    want = distance_km(p);
    if (p.known_km >= 0 && want != 15'(p.known_km))
      $display("%0t predictor disagrees with table: expected %0d actual %0d",
               $time, p.known_km, want);
    while (idle_roll(send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_lat_a <= p.lat_a;
    in_lon_a <= p.lon_a;
    in_lat_b <= p.lat_b;
    in_lon_b <= p.lon_b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_km.push_back(want);
  endtask

  function automatic pair_row_t random_pair(input bit wide);
    pair_row_t p;
    if (wide) begin
      // Any 24/25-bit pattern: latitudes past the pole, longitudes that wrap.
      p.lat_a = 24'($urandom);
      p.lon_a = 25'($urandom);
      p.lat_b = 24'($urandom);
      p.lon_b = 25'($urandom);
    end else begin
      p.lat_a = 24'($signed($urandom_range(2 * LAT_MAX, 0)) - LAT_MAX);
      p.lon_a = 25'($signed($urandom_range(2 * LON_MAX, 0)) - LON_MAX);
      if ($urandom_range(3, 0) == 0) begin
        // Nearby second point, to probe the small-distance floor.
        p.lat_b = p.lat_a + 24'($signed($urandom_range(2000, 0)) - 1000);
        p.lon_b = p.lon_a + 25'($signed($urandom_range(2000, 0)) - 1000);
      end else begin
        p.lat_b = 24'($signed($urandom_range(2 * LAT_MAX, 0)) - LAT_MAX);
        p.lon_b = 25'($signed($urandom_range(2 * LON_MAX, 0)) - LON_MAX);
      end
    end
    p.known_km = -1;
    return p;
  endfunction

  // Output side: random stall and in-order check against the oldest expectation.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_km.size() == 0) begin
          $display("%0t unexpected result: expected none actual %0d",
                   $time, out_distance_km);
          errors++;
        end else begin
          logic [14:0] want;
          want = pending_km.pop_front();
          if (out_distance_km !== want) begin
            $display("%0t distance_km mismatch: expected %0d actual %0d",
                     $time, want, out_distance_km);
            errors++;
          end
        end
      end
      out_ready <= !idle_roll(recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    pair_row_t table_rows[$];
    pair_row_t p;
    int        phase_len;

    errors = 0;
    results_seen = 0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_lat_a = '0;
    in_lon_a = '0;
    in_lat_b = '0;
    in_lon_b = '0;

    // Identical points, poles, antipodes, field extremes and wrap cases.
    table_rows = '{
      '{24'sd0,        25'sd0,         24'sd0,        25'sd0,         0},
      '{24'sd5898240,  25'sd0,         24'sd5898240,  25'sd0,         0},
      '{24'sd5898240,  25'sd0,         -24'sd5898240, 25'sd0,         -1},
      '{24'sd0,        25'sd0,         24'sd0,        25'sd11796480,  -1},
      '{24'sd0,        -25'sd11796480, 24'sd0,        25'sd11796480,  -1},
      '{-24'sd5898240, -25'sd11796480, 24'sd5898240,  25'sd11796480,  -1},
      '{24'sd0,        25'sd0,         24'sd0,        25'sd5898240,   -1},
      '{24'sd3342336,  25'sd147456,    24'sd2662400,  -25'sd4845568,  -1},
      '{24'sd8388607,  25'sd16777215,  -24'sd8388608, -25'sd16777216, -1},
      '{-24'sd8388608, -25'sd16777216, 24'sd8388607,  25'sd16777215,  -1},
      '{24'sd0,        25'sd23592960,  24'sd0,        25'sd0,         -1},
      '{24'sd11796480, 25'sd0,         24'sd0,        25'sd0,         -1},
      '{24'sd0,        25'sd0,         24'sd1,        25'sd1,         -1},
      '{24'sd100,      25'sd100,       24'sd101,      25'sd100,       -1},
      '{24'sd1,        25'sd0,         -24'sd1,       25'sd11796480,  -1},
      '{-24'sd1,       -25'sd1,        -24'sd1,       -25'sd1,        0},
      '{24'sd4194303,  25'sd8388607,   -24'sd4194304, -25'sd8388608,  -1},
      '{24'sd2949120,  25'sd2949120,   -24'sd2949120, -25'sd8847360,  -1}
    };

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) send_pair(table_rows[i]);
    in_valid <= 1'b0;

    // Let the pipeline drain fully once before the random traffic starts.
    while (pending_km.size() != 0) @(posedge clk);

    phase_len = N_RANDOM / 3;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n < phase_len) begin
        send_idle_pct = 33; recv_idle_pct = 69;
      end else if (n < 2 * phase_len) begin
        send_idle_pct = 69; recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      p = random_pair($urandom_range(9, 0) == 0);
      send_pair(p);
    end
    in_valid <= 1'b0;

    while (pending_km.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("Sent %0d directed and %0d random point pairs, %0d distances checked.",
             table_rows.size(), N_RANDOM, results_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
